// ----- rtl/ctcg_pkg.sv -----
// ---------------------------------------------------------------------------
// ctcg_pkg
// Shared constants for the greedy CTC decoder: register map, register
// widths, reset values and parameter defaults.
// ---------------------------------------------------------------------------
package ctcg_pkg;

  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLASS_COUNT = 1'b0,
    REG_KEY_COUNT   = 1'b1
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] CLASS_COUNT_RST = 14'd8192;
  localparam logic [CFG_W-1:0] KEY_COUNT_RST   = 14'd8192;

  localparam int DEF_MAX_CLASSES = 8192;
  localparam int DEF_SCORE_WIDTH = 16;

endpackage

// ----- rtl/ctcg_out_skid.sv -----
// ---------------------------------------------------------------------------
// ctcg_out_skid
// Two-entry output buffer: an output register backed by a skid register,
// so the upstream side keeps taking items while a result waits.
// ---------------------------------------------------------------------------
module ctcg_out_skid #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic             out_v_r, out_v_nxt;
  logic             skid_v_r, skid_v_nxt;
  logic [WIDTH-1:0] out_d_r, out_d_nxt;
  logic [WIDTH-1:0] skid_d_r, skid_d_nxt;

  assign in_ready  = !skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_d_nxt  = out_d_r;
    skid_d_nxt = skid_d_r;
    if (in_valid && !skid_v_r) begin
      if (!out_v_r || out_ready) begin
        out_v_nxt = 1'b1;
        out_d_nxt = in_data;
      end else begin
        skid_v_nxt = 1'b1;
        skid_d_nxt = in_data;
      end
    end else if (out_v_r && out_ready) begin
      out_v_nxt  = skid_v_r;
      out_d_nxt  = skid_d_r;
      skid_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held while output register empty");

  a_skid_drains_first: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_ready && skid_v_r) |=> (out_v_r && out_d_r == $past(skid_d_r)))
    else $error("skid entry not moved to output register");

  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ready) |=> (out_v_r && out_d_r == $past(out_d_r)))
    else $error("pending result lost or changed");
`endif

endmodule

// ----- rtl/ctc_greedy_decoder_unit.sv -----
// ---------------------------------------------------------------------------
// ctc_greedy_decoder_unit
// Greedy CTC decoder: running argmax over the class scores of each time
// step, one result per step, char_valid when the winner is a new non-blank key.
// ---------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  in_      in   in_tvalid/in_tready    tdata score, tuser class_enabled,
//                                       tlast line_end
//  out_     out  out_tvalid/out_tready  tdata class_index, best_score,
//                                       tuser char_valid, tlast line_done
//  cfg_     in   cfg_valid/cfg_ready    cfg_index register, cfg_data value
//
//  One score per cycle; the result of a step is registered into the output
//  register, or the skid register while the output waits, with the item
//  that closes the step. The single compare-and-update on the step state
//  sets that rate. Reset is synchronous, active low. The input stalls only
//  while output and skid entries are both full. cfg_ready is always high.
// ---------------------------------------------------------------------------
module ctc_greedy_decoder_unit #(
  parameter int MAX_CLASSES = ctcg_pkg::DEF_MAX_CLASSES,
  parameter int SCORE_WIDTH = ctcg_pkg::DEF_SCORE_WIDTH,
  parameter int IDX_W       = $clog2(MAX_CLASSES),
  parameter int IN_DATA_W   = ((SCORE_WIDTH + 7) / 8) * 8,
  parameter int OUT_DATA_W  = ((IDX_W + SCORE_WIDTH + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // [SCORE_WIDTH-1:0] score, rest zero
  input  logic [IN_DATA_W-1:0]          in_tdata,
  // class_enabled
  input  logic                          in_tuser,
  input  logic                          in_tlast,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [IDX_W-1:0] class_index, then best_score, rest zero
  output logic [OUT_DATA_W-1:0]         out_tdata,
  // char_valid
  output logic                          out_tuser,
  output logic                          out_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ctcg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ctcg_pkg::CFG_W-1:0]     cfg_data
);

  import ctcg_pkg::*;

  localparam int CNT_W = $clog2(MAX_CLASSES + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int PAY_W = IDX_W + SCORE_WIDTH + 2;
  localparam logic [SCORE_WIDTH-1:0] SCORE_MIN = {1'b1, {(SCORE_WIDTH-1){1'b0}}};
  localparam logic [CMP_W-1:0] MAX_CNT = CMP_W'(MAX_CLASSES);

  logic [CFG_W-1:0]        class_count_r, key_count_r;
  logic [IDX_W-1:0]        pos_r, pos_nxt;
  logic [SCORE_WIDTH-1:0]  max_r, max_nxt;
  logic [IDX_W-1:0]        argmax_r, argmax_nxt;
  logic                    seen_r, seen_nxt;
  logic [IDX_W-1:0]        prev_r, prev_nxt;

  logic                    in_acc;
  logic signed [SCORE_WIDTH-1:0] score;
  logic                    enabled, upd, step_end, emit, any_win;
  logic [CMP_W-1:0]        count_raw, count_eff, pos_inc;
  logic [IDX_W-1:0]        win;
  logic [SCORE_WIDTH-1:0]  win_score;
  logic [PAY_W-1:0]        res_data, buf_data;
  logic                    buf_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_count_r <= CLASS_COUNT_RST;
      key_count_r   <= KEY_COUNT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CLASS_COUNT: class_count_r <= cfg_data;
        REG_KEY_COUNT:   key_count_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_tready = buf_ready;
  assign in_acc    = in_tvalid && in_tready;
  assign score     = in_tdata[SCORE_WIDTH-1:0];
  assign enabled   = in_tuser || (pos_r == '0);
  assign upd       = enabled && (!seen_r || (score > $signed(max_r)));

  assign count_raw = CMP_W'(class_count_r);
  assign count_eff = (count_raw > MAX_CNT) ? MAX_CNT : count_raw;
  assign pos_inc   = CMP_W'(pos_r) + 1'b1;
  assign step_end  = in_tlast || (pos_inc >= count_eff);

  assign any_win   = seen_r || upd;
  assign win       = !any_win ? '0 : (upd ? pos_r : argmax_r);
  assign win_score = !any_win ? SCORE_MIN : (upd ? score : max_r);
  assign emit      = (win != '0) && (CMP_W'(win) < CMP_W'(key_count_r)) && (win != prev_r);

  always_comb begin
    pos_nxt    = pos_r;
    max_nxt    = max_r;
    argmax_nxt = argmax_r;
    seen_nxt   = seen_r;
    prev_nxt   = prev_r;
    if (in_acc) begin
      if (step_end) begin
        pos_nxt    = '0;
        max_nxt    = SCORE_MIN;
        argmax_nxt = '0;
        seen_nxt   = 1'b0;
        prev_nxt   = in_tlast ? '0 : win;
      end else begin
        pos_nxt    = pos_inc[IDX_W-1:0];
        max_nxt    = win_score;
        argmax_nxt = win;
        seen_nxt   = any_win;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      max_r    <= SCORE_MIN;
      argmax_r <= '0;
      seen_r   <= 1'b0;
      prev_r   <= '0;
    end else begin
      pos_r    <= pos_nxt;
      max_r    <= max_nxt;
      argmax_r <= argmax_nxt;
      seen_r   <= seen_nxt;
      prev_r   <= prev_nxt;
    end
  end

  assign res_data = {in_tlast, emit, win_score, win};

  ctcg_out_skid #(
    .WIDTH(PAY_W)
  ) u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_acc && step_end),
    .in_ready (buf_ready),
    .in_data  (res_data),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (buf_data)
  );

  assign out_tdata = OUT_DATA_W'(buf_data[IDX_W+SCORE_WIDTH-1:0]);
  assign out_tuser = buf_data[PAY_W-2];
  assign out_tlast = buf_data[PAY_W-1];

`ifndef SYNTHESIS
  a_line_clears_prev: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (prev_r == '0))
    else $error("previous winner not cleared at line end");

  a_step_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && step_end) |=> (pos_r == '0 && !seen_r))
    else $error("class position not cleared at step end");

  a_pos_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !step_end) |=> (pos_r == IDX_W'($past(pos_r) + 1'b1) && seen_r))
    else $error("class position did not advance");
`endif

endmodule

// ----- tb/ctc_greedy_decoder_unit_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ctc_greedy_decoder_unit_tb
// Self-checking bench for the greedy CTC decoder. Score items stream in with
// random gaps while the result side stalls at random. A local model of the
// argmax and collapse logic predicts every step result, and each result is
// compared field by field in arrival order. Directed steps cover blank
// handling, ties, disabled classes, repeats, early line end and register
// extremes. Random lines follow over many register settings and idle mixes,
// then short lines at large register values.
// ---------------------------------------------------------------------------
module ctc_greedy_decoder_unit_tb;
  import ctcg_pkg::*;

  localparam int IDX_W       = 13;
  localparam int SC_W        = 16;
  localparam int OUT_W       = 32;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 16;
  localparam int MAX_SHOWN   = 10;
  localparam int PHASE_ITEMS = 25;
  localparam logic [SC_W-1:0] SC_MIN = 16'h8000;
  localparam logic [SC_W-1:0] SC_MAX = 16'h7FFF;

  typedef struct packed {
    logic             char_valid;
    logic [IDX_W-1:0] class_index;
    logic [SC_W-1:0]  best_score;
    logic             line_done;
  } step_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic [SC_W-1:0]  in_tdata;
  logic             in_tuser;
  logic             in_tlast;
  logic             in_tvalid;
  logic             in_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tuser;
  logic             out_tlast;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic             cfg_valid;
  logic             cfg_ready;
  cfg_reg_t         cfg_index;
  logic [CFG_W-1:0] cfg_data;

  // decoder model state
  int                     cfg_classes;
  int                     cfg_keys;
  int                     cls_pos;
  logic signed [SC_W-1:0] run_max;
  logic [IDX_W-1:0]       run_arg;
  logic                   any_seen;
  logic [IDX_W-1:0]       prev_arg;
  step_result_t           pending_q[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;
  int stall_cycles = 0;
  int n_items = 0;
  int n_results = 0;
  int n_chars = 0;
  int n_lines = 0;
  int n_writes = 0;

  ctc_greedy_decoder_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= int'($urandom_range(99)) >= recv_idle_pct;
  end

  function automatic int classes_per_step();
    if (cfg_classes < 2) return 1;
    if (cfg_classes > DEF_MAX_CLASSES) return DEF_MAX_CLASSES;
    return cfg_classes;
  endfunction

  task automatic decode_score(input logic [SC_W-1:0] raw, input logic en_in,
                              input logic le);
    logic signed [SC_W-1:0] s;
    logic                   en;
    step_result_t           r;
    s  = raw;
    en = en_in || (cls_pos == 0);
    if (en && (!any_seen || s > run_max)) begin
      run_max  = s;
      run_arg  = IDX_W'(cls_pos);
      any_seen = 1'b1;
    end
    if (!le && (cls_pos + 1 < classes_per_step())) begin
      cls_pos++;
    end else begin
      r.class_index = any_seen ? run_arg : '0;
      r.best_score  = any_seen ? run_max : SC_MIN;
      r.char_valid  = (r.class_index != 0) && (int'(r.class_index) < cfg_keys) &&
                      (r.class_index != prev_arg);
      r.line_done   = le;
      pending_q = {pending_q, r};
      prev_arg = le ? '0 : r.class_index;
      cls_pos  = 0;
      run_max  = SC_MIN;
      run_arg  = '0;
      any_seen = 1'b0;
    end
  endtask

  always @(posedge clk) begin : monitor
    step_result_t got;
    step_result_t want;
    bit           moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        moved           = 1'b1;
        got.char_valid  = out_tuser;
        got.class_index = out_tdata[IDX_W-1:0];
        got.best_score  = out_tdata[IDX_W+SC_W-1:IDX_W];
        got.line_done   = out_tlast;
        if (pending_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN)
            $display("unexpected result: char=%0b idx=%0d score=%h last=%0b",
                     got.char_valid, got.class_index, got.best_score, got.line_done);
        end else begin
          want = pending_q.pop_front();
          n_results++;
          if (want.char_valid) n_chars++;
          if (want.line_done) n_lines++;
          if (got !== want || out_tdata[OUT_W-1:IDX_W+SC_W] !== '0) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN)
              $display("mismatch: exp %0b %0d %h %0b, act %0b %0d %h %0b pad %h",
                       want.char_valid, want.class_index, want.best_score, want.line_done,
                       got.char_valid, got.class_index, got.best_score, got.line_done,
                       out_tdata[OUT_W-1:IDX_W+SC_W]);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        moved = 1'b1;
        decode_score(in_tdata, in_tuser, in_tlast);
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        case (cfg_index)
          REG_CLASS_COUNT: cfg_classes = int'(cfg_data);
          REG_KEY_COUNT:   cfg_keys    = int'(cfg_data);
          default: ;
        endcase
      end
    end
    if (moved) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("ctc_greedy_decoder_unit test failed");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [SC_W-1:0] sc, input logic en, input logic le);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sc;
    in_tuser  <= en;
    in_tlast  <= le;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    n_items++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    n_writes++;
  endtask

  task automatic set_regs(input int classes, input int keys);
    drain_results();
    write_reg(REG_CLASS_COUNT, classes);
    write_reg(REG_KEY_COUNT, keys);
  endtask

  function automatic logic [SC_W-1:0] rand_score();
    case ($urandom_range(9))
      0:       return SC_MIN;
      1:       return SC_MAX;
      2, 3:    return SC_W'(int'($urandom_range(4)) - 2);
      default: return SC_W'($urandom);
    endcase
  endfunction

  // tgt < 0: no planted winner; classes before tgt never reach SC_MAX
  task automatic send_step(input int n, input bit le, input int tgt);
    logic [SC_W-1:0] sc;
    logic            en;
    for (int i = 0; i < n; i++) begin
      sc = rand_score();
      en = $urandom_range(3) != 0;
      if (i < tgt && sc == SC_MAX) sc = SC_MAX - 1;
      if (i == tgt) begin
        sc = SC_MAX;
        en = 1'b1;
      end
      send_item(sc, en, le && (i == n - 1));
    end
  endtask

  task automatic send_line();
    int nsteps;
    int n;
    int tgt;
    int prev_tgt;
    bit le;
    nsteps   = $urandom_range(1, 4);
    prev_tgt = -1;
    for (int st = 0; st < nsteps; st++) begin
      n  = classes_per_step();
      le = (st == nsteps - 1);
      if (le && $urandom_range(3) == 0) n = $urandom_range(1, n);
      case ($urandom_range(5))
        0, 1:    tgt = prev_tgt;
        2:       tgt = -1;
        default: tgt = $urandom_range(0, n - 1);
      endcase
      if (tgt >= n) tgt = -1;
      prev_tgt = tgt;
      send_step(n, le, tgt);
    end
  endtask

  task automatic test_directed();
    send_idle_pct = 21;
    recv_idle_pct = 71;
    // reset registers; blank counts with enable low; line closed early
    send_item(16'h0000, 1'b0, 1'b0);
    send_item(16'h8001, 1'b1, 1'b0);
    send_item(SC_MAX,   1'b0, 1'b1);
    set_regs(3, 3);
    // new key
    send_item(SC_MIN,   1'b1, 1'b0);
    send_item(16'h1234, 1'b1, 1'b0);
    send_item(SC_MAX,   1'b1, 1'b0);
    // same key again, collapsed
    send_item(16'hFFFF, 1'b1, 1'b0);
    send_item(16'h0001, 1'b1, 1'b0);
    send_item(16'h0002, 1'b1, 1'b0);
    // disabled class cannot win
    send_item(SC_MIN,   1'b0, 1'b0);
    send_item(16'h0100, 1'b1, 1'b0);
    send_item(SC_MAX,   1'b0, 1'b0);
    // three-way tie, blank keeps it
    send_item(16'h0005, 1'b1, 1'b0);
    send_item(16'h0005, 1'b1, 1'b0);
    send_item(16'h0005, 1'b1, 1'b0);
    // early line end
    send_item(SC_MIN,   1'b1, 1'b0);
    send_item(SC_MAX,   1'b1, 1'b1);
    // winner at key count, not emitted
    set_regs(3, 2);
    send_item(SC_MIN,   1'b1, 1'b0);
    send_item(16'h0000, 1'b1, 1'b0);
    send_item(SC_MAX,   1'b1, 1'b1);
    // zero and one classes: every item is a step
    set_regs(0, 1);
    send_item(SC_MAX,   1'b1, 1'b0);
    send_item(SC_MIN,   1'b0, 1'b1);
    set_regs(1, 8192);
    send_item(16'h1234, 1'b1, 1'b1);
    // key count zero
    set_regs(2, 0);
    send_item(SC_MIN,   1'b1, 1'b0);
    send_item(SC_MAX,   1'b1, 1'b1);
  endtask

  task automatic test_random_phases();
    int cc_tab[12];
    int kc_tab[12];
    int start;
    bit paused;
    cc_tab = '{2, 3, 5, 8, 0, 4, 16, 1, 6, 2, 9, 3};
    kc_tab = '{2, 8192, 1, 16383, 2, 0, 12, 3, 4, 16383, 5, 3};
    for (int ip = 0; ip < 3; ip++) begin
      case (ip)
        0: begin send_idle_pct = 21; recv_idle_pct = 71; end
        1: begin send_idle_pct = 71; recv_idle_pct = 21; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int k = 0; k < 4; k++) begin
        set_regs(cc_tab[ip*4+k], kc_tab[ip*4+k]);
        start  = n_items;
        paused = 1'b0;
        while (n_items - start < PHASE_ITEMS) begin
          send_line();
          if (!paused) begin
            drain_results();
            paused = 1'b1;
          end
        end
      end
    end
  endtask

  task automatic test_large_counts();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // count above the class limit acts as the limit; steps closed by line end
    set_regs(16383, 8191);
    send_step(6, 1'b1, 5);
    set_regs(8192, 8192);
    send_step(5, 1'b1, 4);
  endtask

  initial begin
    in_tdata  = '0;
    in_tuser  = 1'b0;
    in_tlast  = 1'b0;
    in_tvalid = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_CLASS_COUNT;
    cfg_data  = '0;
    cfg_classes = int'(CLASS_COUNT_RST);
    cfg_keys    = int'(KEY_COUNT_RST);
    cls_pos  = 0;
    run_max  = SC_MIN;
    run_arg  = '0;
    any_seen = 1'b0;
    prev_arg = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random_phases();
    test_large_counts();

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (pending_q.size() != 0) begin
      fail_count += pending_q.size();
      $display("%0d expected results never arrived", pending_q.size());
    end
    $display("covered %0d score items, %0d step results (%0d characters, %0d line ends)",
             n_items, n_results, n_chars, n_lines);
    $display("over %0d register writes, three idle mixes and large counts; %0d failures",
             n_writes, fail_count);
    if (fail_count == 0) begin
      $display("ctc_greedy_decoder_unit test passed");
    end else begin
      $display("ctc_greedy_decoder_unit test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ctcg_pkg.sv
rtl/ctcg_out_skid.sv
rtl/ctc_greedy_decoder_unit.sv
tb/ctc_greedy_decoder_unit_tb.sv
